/* rtl/vna_pkg.sv */
// vna_pkg: shared types, codes and constants of the vertex normal accumulator.
// No dependencies; every module of the block but vna_ram imports it.
package vna_pkg;

   localparam int MAX_VERTICES_DEF = 1024;
   localparam int COORD_WIDTH_DEF  = 16;
   localparam int INDEX_WIDTH      = 10;
   localparam int POS_WIDTH        = 16;
   localparam int SUM_WIDTH        = 48;
   localparam int MUL_STEPS        = 6;

   // saturation bounds of one normal component
   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_TRI   = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]                   mode;
      logic [INDEX_WIDTH-1:0]       index_a;
      logic [INDEX_WIDTH-1:0]       index_b;
      logic [INDEX_WIDTH-1:0]       index_c;
      logic signed [POS_WIDTH-1:0]  pos_x;
      logic signed [POS_WIDTH-1:0]  pos_y;
      logic signed [POS_WIDTH-1:0]  pos_z;
   } req_word_type;

   typedef struct packed {
      logic signed [SUM_WIDTH-1:0]  sum_x;
      logic signed [SUM_WIDTH-1:0]  sum_y;
      logic signed [SUM_WIDTH-1:0]  sum_z;
      logic                         saturated;
   } rsp_word_type;

   // one entry of the normal store: sticky flag and x, y, z sums
   typedef struct packed {
      logic                         sat;
      logic [2:0][SUM_WIDTH-1:0]    sum;
   } normal_word_type;

   localparam int NORMAL_WORD_BITS = $bits(normal_word_type);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_RISSUE,
      ST_RDONE,
      ST_VRD_A,
      ST_VRD_B,
      ST_VRD_C,
      ST_EDGE,
      ST_MUL,
      ST_NRD,
      ST_NADD,
      ST_NWR
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CAP_A,
      OP_CAP_B,
      OP_EDGE,
      OP_MUL,
      OP_ADD
   } unit_op_type;

   typedef struct packed {
      unit_op_type  op;
      logic [2:0]   step;
      logic [1:0]   comp;
   } unit_ctrl_type;

   // operand order of the cross product e2 x e1, one product per step:
   // x = e2y*e1z - e2z*e1y, y = e2z*e1x - e2x*e1z, z = e2x*e1y - e2y*e1x
   function automatic logic [1:0] mul_sel_e2(input logic [2:0] k);
      logic [1:0] s;
      case (k)
         3'd0:    s = 2'd1;
         3'd1:    s = 2'd2;
         3'd2:    s = 2'd2;
         3'd3:    s = 2'd0;
         3'd4:    s = 2'd0;
         3'd5:    s = 2'd1;
         default: s = 2'd0;
      endcase
      return s;
   endfunction

   function automatic logic [1:0] mul_sel_e1(input logic [2:0] k);
      logic [1:0] s;
      case (k)
         3'd0:    s = 2'd2;
         3'd1:    s = 2'd1;
         3'd2:    s = 2'd0;
         3'd3:    s = 2'd2;
         3'd4:    s = 2'd1;
         3'd5:    s = 2'd0;
         default: s = 2'd0;
      endcase
      return s;
   endfunction

endpackage

/* rtl/vna_ram.sv */
// vna_ram: single-port RAM with registered read, used for vertex and normal stores.
// Depends on nothing but its parameters.
module vna_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int WIDTH = 48
) (
   input  logic             clock,
   input  logic             we,
   input  logic             re,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   // registered read, held while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/vna_unit.sv */
// vna_unit: shared arithmetic of the accumulator - edge subtract, one multiplier,
// one adder that builds the cross product and saturates the normal sums. Uses vna_pkg.
module vna_unit #(
   parameter int COORD_WIDTH = vna_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  vna_pkg::unit_ctrl_type         ctrl,
   input  logic [2:0][COORD_WIDTH-1:0]    vrdata,
   input  vna_pkg::normal_word_type       nrdata,
   output vna_pkg::normal_word_type       work_word
);

   import vna_pkg::*;

   localparam int EW = COORD_WIDTH + 1;
   localparam int PW = 2 * EW;
   localparam int NW = PW + 1;
   localparam int SW = ((NW > SUM_WIDTH) ? NW : SUM_WIDTH) + 1;
   localparam logic signed [SW-1:0] SAT_HI = SW'(SUM_MAX);
   localparam logic signed [SW-1:0] SAT_LO = SW'(SUM_MIN);

   logic [2:0][COORD_WIDTH-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e1_in [3];
   logic signed [EW-1:0] e2_ff [3];
   logic signed [EW-1:0] e2_in [3];
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [NW-1:0] n_ff [3];
   logic signed [NW-1:0] n_in [3];
   logic [2:0][SUM_WIDTH-1:0] work_ff, work_in;
   logic sat_ff, sat_in;

   logic [2:0]            j;
   logic [1:0]            ci;
   logic signed [EW-1:0]  op_a, op_b;
   logic signed [PW-1:0]  mul_res;
   logic signed [SW-1:0]  add_x, add_y, add_res;
   logic                  add_sub;
   logic                  clamp_hi, clamp_lo;
   logic [SUM_WIDTH-1:0]  sat_res;

   // multiplier and shared adder
   always_comb begin
      j        = ctrl.step - 3'd1;
      ci       = j[2:1];
      op_a     = e2_ff[mul_sel_e2(ctrl.step)];
      op_b     = e1_ff[mul_sel_e1(ctrl.step)];
      mul_res  = PW'(op_a) * PW'(op_b);
      add_x    = '0;
      add_y    = '0;
      add_sub  = 1'b0;
      case (ctrl.op)
         OP_MUL: begin
            // even product opens a component, odd product is subtracted
            add_x   = j[0] ? SW'(n_ff[ci]) : '0;
            add_y   = SW'(prod_ff);
            add_sub = j[0];
         end
         OP_ADD: begin
            add_x = SW'($signed(nrdata.sum[ctrl.comp]));
            add_y = SW'(n_ff[ctrl.comp]);
         end
         default: ;
      endcase
      add_res  = add_sub ? (add_x - add_y) : (add_x + add_y);
      clamp_hi = add_res > SAT_HI;
      clamp_lo = add_res < SAT_LO;
      if (clamp_hi) begin
         sat_res = SUM_MAX;
      end else if (clamp_lo) begin
         sat_res = SUM_MIN;
      end else begin
         sat_res = add_res[SUM_WIDTH-1:0];
      end
   end

   // register next values
   always_comb begin
      pa_in   = pa_ff;
      pb_in   = pb_ff;
      e1_in   = e1_ff;
      e2_in   = e2_ff;
      prod_in = prod_ff;
      n_in    = n_ff;
      work_in = work_ff;
      sat_in  = sat_ff;
      case (ctrl.op)
         OP_CAP_A: pa_in = vrdata;
         OP_CAP_B: pb_in = vrdata;
         OP_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               e1_in[i] = EW'($signed(pa_ff[i])) - EW'($signed(pb_ff[i]));
               e2_in[i] = EW'($signed(vrdata[i])) - EW'($signed(pb_ff[i]));
            end
         end
         OP_MUL: begin
            if (ctrl.step < 3'(MUL_STEPS)) begin
               prod_in = mul_res;
            end
            if (ctrl.step != 3'd0) begin
               n_in[ci] = NW'(add_res);
            end
         end
         OP_ADD: begin
            work_in[ctrl.comp] = sat_res;
            sat_in = ((ctrl.comp == 2'd0) ? nrdata.sat : sat_ff) | clamp_hi | clamp_lo;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      e1_ff   <= e1_in;
      e2_ff   <= e2_in;
      prod_ff <= prod_in;
      n_ff    <= n_in;
      work_ff <= work_in;
      sat_ff  <= sat_in;
   end

   assign work_word.sat = sat_ff;
   assign work_word.sum = work_ff;

endmodule

/* rtl/vna_seq.sv */
// vna_seq: sequencer - command capture, store clearing pass, read, write and
// triangle steps; drives memory ports and the shared unit. Uses vna_pkg.
module vna_seq #(
   parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = vna_pkg::COORD_WIDTH_DEF,
   parameter int AW           = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  vna_pkg::req_word_type        req_word,
   output logic                         vmem_we,
   output logic                         vmem_re,
   output logic [AW-1:0]                vmem_addr,
   output logic [2:0][COORD_WIDTH-1:0]  vmem_wdata,
   output logic                         nmem_we,
   output logic                         nmem_re,
   output logic                         nmem_clear,
   output logic [AW-1:0]                nmem_addr,
   output vna_pkg::unit_ctrl_type       ctrl,
   output logic                         rsp_load,
   output logic                         rsp_zero
);

   import vna_pkg::*;

   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

   state_type     state_ff, state_in;
   req_word_type  req_ff, req_in;
   logic          a_ok_ff, a_ok_in, tri_ok;
   logic          b_ok, c_ok, a_ok;
   logic [AW-1:0] clr_ff, clr_in;
   logic [2:0]    step_ff, step_in;
   logic [1:0]    comp_ff, comp_in;
   logic [1:0]    corner_ff, corner_in;
   logic [AW-1:0] addr_a, addr_b, addr_c, addr_corner;
   logic          accept;

   function automatic logic index_ok(input logic [INDEX_WIDTH-1:0] idx);
      return 32'(idx) < 32'(MAX_VERTICES);
   endfunction

   assign accept = start && (state_ff == ST_IDLE);
   assign a_ok   = index_ok(req_word.index_a);
   assign b_ok   = index_ok(req_word.index_b);
   assign c_ok   = index_ok(req_word.index_c);
   assign tri_ok = a_ok && b_ok && c_ok;

   assign addr_a = AW'(req_ff.index_a);
   assign addr_b = AW'(req_ff.index_b);
   assign addr_c = AW'(req_ff.index_c);

   // corner being accumulated
   always_comb begin
      case (corner_ff)
         2'd0:    addr_corner = addr_a;
         2'd1:    addr_corner = addr_b;
         default: addr_corner = addr_c;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_ff == LAST_ADDR) state_in = ST_IDLE;
         ST_IDLE: begin
            if (start) begin
               case (req_word.mode)
                  MODE_WRITE: if (a_ok) state_in = ST_WRITE;
                  MODE_TRI:   if (tri_ok) state_in = ST_VRD_A;
                  MODE_READ:  state_in = a_ok ? ST_RISSUE : ST_RDONE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_WRITE:  state_in = ST_IDLE;
         ST_RISSUE: state_in = ST_RDONE;
         ST_RDONE:  state_in = ST_IDLE;
         ST_VRD_A:  state_in = ST_VRD_B;
         ST_VRD_B:  state_in = ST_VRD_C;
         ST_VRD_C:  state_in = ST_EDGE;
         ST_EDGE:   state_in = ST_MUL;
         ST_MUL:    if (step_ff == 3'(MUL_STEPS)) state_in = ST_NRD;
         ST_NRD:    state_in = ST_NADD;
         ST_NADD:   if (comp_ff == 2'd2) state_in = ST_NWR;
         ST_NWR:    state_in = (corner_ff == 2'd2) ? ST_IDLE : ST_NRD;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy       = (state_ff != ST_IDLE);
      vmem_we    = 1'b0;
      vmem_re    = 1'b0;
      vmem_addr  = addr_a;
      nmem_we    = 1'b0;
      nmem_re    = 1'b0;
      nmem_clear = 1'b0;
      nmem_addr  = addr_a;
      ctrl.op    = OP_NONE;
      ctrl.step  = step_ff;
      ctrl.comp  = comp_ff;
      rsp_load   = 1'b0;
      rsp_zero   = !a_ok_ff;
      case (state_ff)
         ST_CLEAR: begin
            nmem_we    = 1'b1;
            nmem_clear = 1'b1;
            nmem_addr  = clr_ff;
         end
         ST_WRITE: begin
            vmem_we    = 1'b1;
            nmem_we    = 1'b1;
            nmem_clear = 1'b1;
         end
         ST_RISSUE: nmem_re = 1'b1;
         ST_RDONE:  rsp_load = 1'b1;
         ST_VRD_A:  vmem_re = 1'b1;
         ST_VRD_B: begin
            vmem_re   = 1'b1;
            vmem_addr = addr_b;
            ctrl.op   = OP_CAP_A;
         end
         ST_VRD_C: begin
            vmem_re   = 1'b1;
            vmem_addr = addr_c;
            ctrl.op   = OP_CAP_B;
         end
         ST_EDGE:   ctrl.op = OP_EDGE;
         ST_MUL:    ctrl.op = OP_MUL;
         ST_NRD: begin
            nmem_re   = 1'b1;
            nmem_addr = addr_corner;
         end
         ST_NADD: begin
            nmem_addr = addr_corner;
            ctrl.op   = OP_ADD;
         end
         ST_NWR: begin
            nmem_we   = 1'b1;
            nmem_addr = addr_corner;
         end
         default: ;
      endcase
   end

   // counters and command capture
   always_comb begin
      req_in    = accept ? req_word : req_ff;
      a_ok_in   = accept ? a_ok : a_ok_ff;
      clr_in    = clr_ff;
      step_in   = step_ff;
      comp_in   = comp_ff;
      corner_in = corner_ff;
      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + 1'b1;
         ST_IDLE:  corner_in = 2'd0;
         ST_EDGE:  step_in = 3'd0;
         ST_MUL:   step_in = step_ff + 3'd1;
         ST_NRD:   comp_in = 2'd0;
         ST_NADD:  comp_in = comp_ff + 2'd1;
         ST_NWR:   corner_in = corner_ff + 2'd1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         step_ff   <= '0;
         comp_ff   <= '0;
         corner_ff <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         step_ff   <= step_in;
         comp_ff   <= comp_in;
         corner_ff <= corner_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      a_ok_ff <= a_ok_in;
   end

   // position written to the vertex store: low COORD_WIDTH bits of the field
   assign vmem_wdata[0] = COORD_WIDTH'($unsigned(req_ff.pos_x));
   assign vmem_wdata[1] = COORD_WIDTH'($unsigned(req_ff.pos_y));
   assign vmem_wdata[2] = COORD_WIDTH'($unsigned(req_ff.pos_z));

endmodule

/* rtl/vertex_normal_accumulator_core.sv */
// vertex_normal_accumulator_core: top level - vertex and normal stores, sequencer,
// shared arithmetic unit and response register. Uses vna_pkg, vna_ram, vna_seq, vna_unit.
//
//   channel   ports                         handshake
//   request   start, busy, req_word         taken at clock edge with start & !busy
//   response  rsp_strobe, rsp_word          one cycle per word, cannot be held off
//
// Busy: high for a vertex write; for a normal read, its read and response load (out of
// range: the load only) with rsp_strobe in the cycle after; for a triangle, three vertex
// reads, edge step, 7 multiplier steps and three read-modify-writes (read, add per
// component, write) of the normal store through the one adder. Bad-index triangles and
// mode 3 leave busy low. After reset the normal store is cleared, one entry a cycle, with
// busy high. Responses leave on a strobe; there is no output stall.
module vertex_normal_accumulator_core #(
   parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = vna_pkg::COORD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  vna_pkg::req_word_type  req_word,
   output logic                   rsp_strobe,
   output vna_pkg::rsp_word_type  rsp_word
);

   import vna_pkg::*;

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

   logic                         vmem_we, vmem_re, nmem_we, nmem_re, nmem_clear;
   logic [AW-1:0]                vmem_addr, nmem_addr;
   logic [2:0][COORD_WIDTH-1:0]  vmem_wdata, vmem_rdata;
   normal_word_type              nmem_wdata, nmem_rdata, work_word;
   unit_ctrl_type                ctrl;
   logic                         rsp_load, rsp_zero;
   rsp_word_type                 rsp_ff, rsp_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;

   vna_seq #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH),
      .AW           (AW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .vmem_we    (vmem_we),
      .vmem_re    (vmem_re),
      .vmem_addr  (vmem_addr),
      .vmem_wdata (vmem_wdata),
      .nmem_we    (nmem_we),
      .nmem_re    (nmem_re),
      .nmem_clear (nmem_clear),
      .nmem_addr  (nmem_addr),
      .ctrl       (ctrl),
      .rsp_load   (rsp_load),
      .rsp_zero   (rsp_zero)
   );

   // vertex positions, x/y/z in one word
   vna_ram #(
      .DEPTH (MAX_VERTICES),
      .AW    (AW),
      .WIDTH (3 * COORD_WIDTH)
   ) u_vertex_mem (
      .clock (clock),
      .we    (vmem_we),
      .re    (vmem_re),
      .addr  (vmem_addr),
      .wdata (vmem_wdata),
      .rdata (vmem_rdata)
   );

   // normal sums and sticky saturation flag
   assign nmem_wdata = nmem_clear ? '0 : work_word;

   vna_ram #(
      .DEPTH (MAX_VERTICES),
      .AW    (AW),
      .WIDTH (NORMAL_WORD_BITS)
   ) u_normal_mem (
      .clock (clock),
      .we    (nmem_we),
      .re    (nmem_re),
      .addr  (nmem_addr),
      .wdata (nmem_wdata),
      .rdata (nmem_rdata)
   );

   vna_unit #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_unit (
      .clock     (clock),
      .ctrl      (ctrl),
      .vrdata    (vmem_rdata),
      .nrdata    (nmem_rdata),
      .work_word (work_word)
   );

   // response word register
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_strobe_in = rsp_load;
      if (rsp_load) begin
         if (rsp_zero) begin
            rsp_in = '0;
         end else begin
            rsp_in.sum_x     = nmem_rdata.sum[0];
            rsp_in.sum_y     = nmem_rdata.sum[1];
            rsp_in.sum_z     = nmem_rdata.sum[2];
            rsp_in.saturated = nmem_rdata.sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

/* verif/tb.sv */
// tb: self-checking bench for vertex_normal_accumulator_core - a directed table, a run of
// large-magnitude faces and random mesh traffic, checked against an in-bench predictor
// (pinned rows: a hand-written result). Depends on vna_pkg and the core RTL only.
module tb;
   import vna_pkg::*;

   localparam int     NUM_VERTS      = MAX_VERTICES_DEF;
   localparam int     RANDOM_WORDS   = 1350;
   localparam int     WATCHDOG_LIMIT = 4000;
   localparam int     TAIL_CYCLES    = 40;
   localparam int     BIG_FACES      = 48;
   localparam longint SUM_HI         = longint'(SUM_MAX);
   localparam longint SUM_LO         = longint'(SUM_MIN);
   // corners of the large-face run: B is the shared edge origin
   localparam int     SAT_A          = 513;
   localparam int     SAT_B          = 512;
   localparam int     SAT_C          = 514;

   localparam rsp_word_type NO_NORMAL = '0;

   // one row of the directed table; pinned rows carry a hand-written result
   typedef struct packed {
      req_word_type w;
      logic         pinned;
      rsp_word_type want;
   } plan_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   // predictor state: positions, running normal sums and sticky clamp flags
   longint       vtx_pos [NUM_VERTS][3];
   longint       nrm_sum [NUM_VERTS][3];
   bit           nrm_sat [NUM_VERTS];
   bit           vtx_built [NUM_VERTS];
   int           built_list [$];

   rsp_word_type normals_due [$];
   rsp_word_type want_rsp;
   plan_row_type plan [$];
   int           mismatches = 0;
   int           quiet_cycles = 0;
   bit           gaps_on = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   vertex_normal_accumulator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // saturating add of one face normal into one vertex
   task automatic add_to_normal(input int v, input longint nx, input longint ny,
                                input longint nz);
      longint inc [3];
      longint s;
      bit     hit;
      inc[0] = nx;
      inc[1] = ny;
      inc[2] = nz;
      hit = 1'b0;
      for (int k = 0; k < 3; k++) begin
         s = nrm_sum[v][k] + inc[k];
         if (s > SUM_HI) begin
            s = SUM_HI;
            hit = 1'b1;
         end else if (s < SUM_LO) begin
            s = SUM_LO;
            hit = 1'b1;
         end
         nrm_sum[v][k] = s;
      end
      if (hit) nrm_sat[v] = 1'b1;
   endtask

   // effect of one accepted word; indices are 10 bits, so never out of range here
   task automatic predict_mesh_word(input req_word_type w, output bit has_rsp,
                                    output rsp_word_type r);
      longint e1 [3];
      longint e2 [3];
      longint nx, ny, nz;
      int     a, b, c;
      has_rsp = 1'b0;
      r = '0;
      a = int'(w.index_a);
      b = int'(w.index_b);
      c = int'(w.index_c);
      case (mode_type'(w.mode))
         MODE_WRITE: begin
            vtx_pos[a][0] = longint'(w.pos_x);
            vtx_pos[a][1] = longint'(w.pos_y);
            vtx_pos[a][2] = longint'(w.pos_z);
            for (int k = 0; k < 3; k++) nrm_sum[a][k] = 0;
            nrm_sat[a] = 1'b0;
            if (!vtx_built[a]) begin
               vtx_built[a] = 1'b1;
               built_list.push_back(a);
            end
         end
         MODE_TRI: begin
            for (int k = 0; k < 3; k++) begin
               e1[k] = vtx_pos[a][k] - vtx_pos[b][k];
               e2[k] = vtx_pos[c][k] - vtx_pos[b][k];
            end
            // n = e2 x e1, added to A, B, C in turn
            nx = e2[1] * e1[2] - e2[2] * e1[1];
            ny = e2[2] * e1[0] - e2[0] * e1[2];
            nz = e2[0] * e1[1] - e2[1] * e1[0];
            add_to_normal(a, nx, ny, nz);
            add_to_normal(b, nx, ny, nz);
            add_to_normal(c, nx, ny, nz);
         end
         MODE_READ: begin
            r.sum_x = SUM_WIDTH'(nrm_sum[a][0]);
            r.sum_y = SUM_WIDTH'(nrm_sum[a][1]);
            r.sum_z = SUM_WIDTH'(nrm_sum[a][2]);
            r.saturated = nrm_sat[a];
            has_rsp = 1'b1;
         end
         default: ;
      endcase
   endtask

   function automatic req_word_type junk_word();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(req_word_type)-1:0];
   endfunction

   function automatic req_word_type mk(input mode_type m, input int a, input int b,
                                       input int c, input int x, input int y, input int z);
      req_word_type w;
      w.mode = m;
      w.index_a = INDEX_WIDTH'(a);
      w.index_b = INDEX_WIDTH'(b);
      w.index_c = INDEX_WIDTH'(c);
      w.pos_x = POS_WIDTH'(x);
      w.pos_y = POS_WIDTH'(y);
      w.pos_z = POS_WIDTH'(z);
      return w;
   endfunction

   // offer one word, idling at random, until the core takes it
   task automatic send_word(input req_word_type w, input bit pinned,
                            input rsp_word_type pinned_rsp);
      bit           offer;
      bit           has_rsp;
      rsp_word_type r;
      do begin
         offer = !(gaps_on && $urandom_range(99) < 32);
         start <= offer;
         req_word <= offer ? w : junk_word();
         @(posedge clock);
      end while (!(offer && !busy));
      predict_mesh_word(w, has_rsp, r);
      if (has_rsp) normals_due.push_back(pinned ? pinned_rsp : r);
   endtask

   function automatic logic signed [POS_WIDTH-1:0] pick_coord();
      logic [31:0] bits;
      bits = $urandom;
      case ($urandom_range(9))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shffff;
         default: return bits[POS_WIDTH-1:0];
      endcase
   endfunction

   function automatic int pick_write_index();
      int roll;
      roll = $urandom_range(9);
      if (roll < 5) return $urandom_range(15);
      if (roll < 8) return $urandom_range(NUM_VERTS - 1, NUM_VERTS - 16);
      return $urandom_range(NUM_VERTS - 1);
   endfunction

   // mostly recent vertices, so sums build up across neighbouring faces
   function automatic int pick_built();
      int n;
      n = built_list.size();
      if ($urandom_range(99) < 75) return built_list[n - 1 - $urandom_range(n < 12 ? n - 1 : 11)];
      return built_list[$urandom_range(n - 1)];
   endfunction

   // response check: one word per strobe against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (normals_due.size() == 0) begin
            $error("response word with no read outstanding");
            mismatches++;
         end else begin
            want_rsp = normals_due.pop_front();
            if (rsp_word.sum_x !== want_rsp.sum_x) begin
               $error("sum_x: expected %0d, got %0d", want_rsp.sum_x, rsp_word.sum_x);
               mismatches++;
            end
            if (rsp_word.sum_y !== want_rsp.sum_y) begin
               $error("sum_y: expected %0d, got %0d", want_rsp.sum_y, rsp_word.sum_y);
               mismatches++;
            end
            if (rsp_word.sum_z !== want_rsp.sum_z) begin
               $error("sum_z: expected %0d, got %0d", want_rsp.sum_z, rsp_word.sum_z);
               mismatches++;
            end
            if (rsp_word.saturated !== want_rsp.saturated) begin
               $error("saturated: expected %0b, got %0b", want_rsp.saturated,
                      rsp_word.saturated);
               mismatches++;
            end
         end
      end
   end

   // watchdog: cycles with no word taken and none returned
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      req_word_type w;
      int           sent;
      int           roll;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;

      // directed table: store cleared after reset, extremes, repeated corners,
      // clearing by rewrite and the unused mode
      plan.push_back('{mk(MODE_READ, 0, 0, 0, 0, 0, 0), 1'b1, NO_NORMAL});
      plan.push_back('{mk(MODE_READ, 1023, 0, 0, 0, 0, 0), 1'b1, NO_NORMAL});
      plan.push_back('{mk(MODE_NONE, 1023, 1023, 1023, 32767, -1, -32768), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_WRITE, 0, 1023, 1023, 32767, -32768, 32767), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_WRITE, 1023, 0, 0, -32768, 32767, -1), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_WRITE, 1, 0, 0, 0, 0, -32768), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_READ, 0, 0, 0, 0, 0, 0), 1'b1, NO_NORMAL});
      plan.push_back('{mk(MODE_TRI, 0, 1023, 1, 0, 0, 0), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_TRI, 1, 0, 1023, -1, -1, -1), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_READ, 0, 0, 0, 0, 0, 0), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_READ, 1023, 1023, 1023, 0, 0, 0), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_READ, 1, 0, 0, 0, 0, 0), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_TRI, 0, 0, 0, 0, 0, 0), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_TRI, 1023, 1, 1023, 0, 0, 0), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_TRI, 0, 0, 1, 0, 0, 0), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_READ, 0, 0, 0, 0, 0, 0), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_READ, 1023, 0, 0, 0, 0, 0), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_WRITE, 1023, 0, 0, 1, 1, 1), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_READ, 1023, 0, 0, 0, 0, 0), 1'b1, NO_NORMAL});
      plan.push_back('{mk(MODE_NONE, 0, 0, 0, 0, 0, 0), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_READ, 0, 1023, 1023, -1, -1, -1), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_WRITE, 2, 0, 0, -1, -1, -1), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_TRI, 2, 1, 0, 0, 0, 0), 1'b0, NO_NORMAL});
      plan.push_back('{mk(MODE_READ, 2, 0, 0, 0, 0, 0), 1'b0, NO_NORMAL});

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_word(plan[i].w, plan[i].pinned, plan[i].want);

      // large faces: each adds (-K, 0, +K), K = 65535^2, building wide sums
      gaps_on = 1'b0;
      send_word(mk(MODE_WRITE, SAT_B, 0, 0, -32768, -32768, -32768), 1'b0, NO_NORMAL);
      send_word(mk(MODE_WRITE, SAT_A, 0, 0, -32768, 32767, -32768), 1'b0, NO_NORMAL);
      send_word(mk(MODE_WRITE, SAT_C, 0, 0, 32767, -32768, 32767), 1'b0, NO_NORMAL);
      repeat (BIG_FACES)
         send_word(mk(MODE_TRI, SAT_A, SAT_B, SAT_C, 0, 0, 0), 1'b0, NO_NORMAL);
      send_word(mk(MODE_READ, SAT_A, 0, 0, 0, 0, 0), 1'b0, NO_NORMAL);
      send_word(mk(MODE_READ, SAT_B, 0, 0, 0, 0, 0), 1'b0, NO_NORMAL);
      send_word(mk(MODE_READ, SAT_C, 0, 0, 0, 0, 0), 1'b0, NO_NORMAL);
      // reversed winding pulls the sums back towards zero
      repeat (3) send_word(mk(MODE_TRI, SAT_C, SAT_B, SAT_A, 0, 0, 0), 1'b0, NO_NORMAL);
      send_word(mk(MODE_READ, SAT_A, 0, 0, 0, 0, 0), 1'b0, NO_NORMAL);
      send_word(mk(MODE_WRITE, SAT_A, 0, 0, 256, 512, -256), 1'b0, NO_NORMAL);
      send_word(mk(MODE_READ, SAT_A, 0, 0, 0, 0, 0), 1'b1, NO_NORMAL);

      // random mesh traffic; unused fields carry junk
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         gaps_on = !(sent >= 600 && sent < 800);
         w = junk_word();
         roll = $urandom_range(99);
         if (built_list.size() < 3 || roll < 30) begin
            w.mode = MODE_WRITE;
            w.index_a = INDEX_WIDTH'(pick_write_index());
            w.pos_x = pick_coord();
            w.pos_y = pick_coord();
            w.pos_z = pick_coord();
            sent++;
         end else if (roll < 65) begin
            w.mode = MODE_TRI;
            w.index_a = INDEX_WIDTH'(pick_built());
            w.index_b = INDEX_WIDTH'(pick_built());
            w.index_c = INDEX_WIDTH'(pick_built());
            case ($urandom_range(19))
               0: w.index_b = w.index_a;
               1: w.index_c = w.index_a;
               2: w.index_c = w.index_b;
               3: begin
                  w.index_b = w.index_a;
                  w.index_c = w.index_a;
               end
               default: ;
            endcase
            sent++;
         end else if (roll < 95) begin
            w.mode = MODE_READ;
            roll = $urandom_range(99);
            if (roll < 60) w.index_a = INDEX_WIDTH'(built_list[built_list.size() - 1 -
                                        $urandom_range(built_list.size() < 12 ?
                                                       built_list.size() - 1 : 11)]);
            else if (roll < 85) w.index_a =
               INDEX_WIDTH'(built_list[$urandom_range(built_list.size() - 1)]);
            else w.index_a = INDEX_WIDTH'($urandom_range(NUM_VERTS - 1));
            sent++;
         end else begin
            w.mode = MODE_NONE;
         end
         send_word(w, 1'b0, NO_NORMAL);
      end

      // drain, then let the last triangle finish
      start <= 1'b0;
      while (normals_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule

/* vertex_normal_accumulator_core.f */
rtl/vna_pkg.sv
rtl/vna_ram.sv
rtl/vna_unit.sv
rtl/vna_seq.sv
rtl/vertex_normal_accumulator_core.sv
verif/tb.sv
